/* rtl/autocorrelation_pitch_candidates_core_macros.svh */
// ----------------------------------------------------------------------------
// autocorrelation pitch candidates core assertion macros
// concurrent assertion wrappers on clk_i, removable with ASSERT_OFF
// ----------------------------------------------------------------------------
`ifndef AUTOCORRELATION_PITCH_CANDIDATES_CORE_MACROS_SVH
`define AUTOCORRELATION_PITCH_CANDIDATES_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define ACPC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define ACPC_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define ACPC_ASSERT(name, prop, msg)
`define ACPC_ASSERT_ALWAYS(name, prop, msg)
`endif
`endif

/* rtl/acpc_pkg.sv */
// ----------------------------------------------------------------------------
// acpc_pkg
// shared constants and types of the autocorrelation pitch candidates core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package acpc_pkg;
  localparam int MAX_FRAME = 1024;
  localparam int FRAME_AW  = $clog2(MAX_FRAME);
  localparam int LEN_W     = FRAME_AW + 1;
  localparam int MIN_LAG   = 30;
  localparam int MAX_LAG   = 400;
  localparam int LAG_COUNT = MAX_LAG - MIN_LAG + 1;
  localparam int LAG_W     = $clog2(MAX_LAG + 1);
  localparam int OFF_W     = $clog2(LAG_COUNT);
  localparam int MAX_CAND  = 8;
  localparam int CNT_W     = $clog2(MAX_CAND + 1);
  localparam int OIDX_W    = $clog2(MAX_CAND);
  localparam int SAMPLE_W  = 16;
  localparam int PROD_W    = 2 * SAMPLE_W;
  localparam int EN_W      = 2 * SAMPLE_W + FRAME_AW - 1;
  localparam int XY_W      = EN_W + 1;
  localparam int ENERGY_W  = 2 * EN_W;
  localparam int K_W       = SAMPLE_W - 1;
  localparam int T2_W      = 2 * K_W;
  localparam int ACC_W     = ENERGY_W + T2_W;
  localparam int SCORE_W   = SAMPLE_W;
  localparam int FREQ_W    = 17;
  localparam int SR_W      = 18;
  localparam int LIM_W     = 4;
  localparam int DVD_W     = SR_W + 4;
  localparam int CFG_W     = 18;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CAND_LIMIT  = 1'b1;

  localparam logic [SR_W-1:0]  SR_RESET  = 18'd48000;
  localparam logic [LIM_W-1:0] LIM_RESET = 4'd4;

  typedef struct packed {
    logic [LAG_W-1:0]          lag;
    logic signed [SCORE_W-1:0] score;
  } cand_t;

  typedef struct packed {
    logic signed [XY_W-1:0] xy;
    logic [EN_W-1:0]        xx;
    logic [EN_W-1:0]        yy;
  } corr_sums_t;
endpackage

/* rtl/acpc_ram.sv */
// ----------------------------------------------------------------------------
// acpc_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module acpc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

/* rtl/acpc_corr.sv */
// ----------------------------------------------------------------------------
// acpc_corr
// frame store and correlation sums xy, xx, yy for one lag on one multiplier
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module acpc_corr (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               wr_en_i,
  input  logic [acpc_pkg::FRAME_AW-1:0]      wr_addr_i,
  input  logic [acpc_pkg::SAMPLE_W-1:0]      wr_data_i,
  input  logic                               start_i,
  input  logic [acpc_pkg::LEN_W-1:0]         len_i,
  input  logic [acpc_pkg::LAG_W-1:0]         lag_i,
  output logic                               done_o,
  output acpc_pkg::corr_sums_t               sums_o
);
  localparam logic [2:0] C_IDLE  = 3'd0;
  localparam logic [2:0] C_WAIT  = 3'd1;
  localparam logic [2:0] C_XY    = 3'd2;
  localparam logic [2:0] C_XX    = 3'd3;
  localparam logic [2:0] C_YY    = 3'd4;
  localparam logic [2:0] C_FLUSH = 3'd5;
  localparam logic [2:0] C_DONE  = 3'd6;

  localparam logic [1:0] P_NONE = 2'd0;
  localparam logic [1:0] P_XY   = 2'd1;
  localparam logic [1:0] P_XX   = 2'd2;
  localparam logic [1:0] P_YY   = 2'd3;

  logic [2:0]                           state_q, state_d;
  logic [acpc_pkg::FRAME_AW-1:0]        idx_q, idx_d, last_q, last_d, y_addr;
  logic [acpc_pkg::LAG_W-1:0]           lag_q, lag_d;
  logic [1:0]                           psel_q, psel_d;
  logic signed [acpc_pkg::PROD_W-1:0]   prod_q, prod_d;
  acpc_pkg::corr_sums_t                 sums_q, sums_d;
  logic [acpc_pkg::SAMPLE_W-1:0]        x_raw, y_raw;
  logic signed [acpc_pkg::SAMPLE_W-1:0] op_a, op_b;

  assign y_addr = idx_q + acpc_pkg::FRAME_AW'(lag_q);

  acpc_ram #(.WIDTH(acpc_pkg::SAMPLE_W), .DEPTH(acpc_pkg::MAX_FRAME)) u_x_ram (
    .clk_i(clk_i), .we_i(wr_en_i), .waddr_i(wr_addr_i), .wdata_i(wr_data_i),
    .raddr_i(idx_q), .rdata_o(x_raw)
  );

  acpc_ram #(.WIDTH(acpc_pkg::SAMPLE_W), .DEPTH(acpc_pkg::MAX_FRAME)) u_y_ram (
    .clk_i(clk_i), .we_i(wr_en_i), .waddr_i(wr_addr_i), .wdata_i(wr_data_i),
    .raddr_i(y_addr), .rdata_o(y_raw)
  );

  // shared multiplier operand select
  always_comb begin
    op_a = $signed(x_raw);
    op_b = $signed(y_raw);
    case (state_q)
      C_XX: op_b = $signed(x_raw);
      C_YY: op_a = $signed(y_raw);
      default: ;
    endcase
  end

  assign prod_d = op_a * op_b;

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    last_d  = last_q;
    lag_d   = lag_q;
    psel_d  = P_NONE;
    sums_d  = sums_q;
    case (psel_q)
      P_XY: sums_d.xy = sums_q.xy + acpc_pkg::XY_W'(prod_q);
      P_XX: sums_d.xx = sums_q.xx + acpc_pkg::EN_W'($unsigned(prod_q));
      P_YY: sums_d.yy = sums_q.yy + acpc_pkg::EN_W'($unsigned(prod_q));
      default: ;
    endcase
    unique case (state_q)
      C_IDLE: begin
        if (start_i) begin
          idx_d   = '0;
          lag_d   = lag_i;
          last_d  = acpc_pkg::FRAME_AW'(len_i - acpc_pkg::LEN_W'(lag_i)
                                        - acpc_pkg::LEN_W'(1));
          sums_d  = '0;
          state_d = C_WAIT;
        end
      end
      C_WAIT: state_d = C_XY;
      C_XY: begin
        psel_d  = P_XY;
        state_d = C_XX;
      end
      C_XX: begin
        psel_d  = P_XX;
        state_d = C_YY;
      end
      C_YY: begin
        psel_d = P_YY;
        if (idx_q == last_q) begin
          state_d = C_FLUSH;
        end else begin
          idx_d   = idx_q + acpc_pkg::FRAME_AW'(1);
          state_d = C_WAIT;
        end
      end
      C_FLUSH: state_d = C_DONE;
      C_DONE:  state_d = C_IDLE;
      default: state_d = C_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      psel_q  <= P_NONE;
    end else begin
      state_q <= state_d;
      psel_q  <= psel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    last_q <= last_d;
    lag_q  <= lag_d;
    prod_q <= prod_d;
    sums_q <= sums_d;
  end

  assign done_o = (state_q == C_DONE);
  assign sums_o = sums_q;
endmodule

/* rtl/acpc_score.sv */
// ----------------------------------------------------------------------------
// acpc_score
// normalized score from correlation sums on one shift-add multiply unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module acpc_score (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  acpc_pkg::corr_sums_t              sums_i,
  output logic                              done_o,
  output logic signed [acpc_pkg::SCORE_W-1:0] score_o
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EMUL = 3'd1;
  localparam logic [2:0] S_TMUL = 3'd2;
  localparam logic [2:0] S_KSQ  = 3'd3;
  localparam logic [2:0] S_KMUL = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]                           state_q, state_d;
  logic [acpc_pkg::ACC_W-1:0]           acc_q, acc_d, mcand_q, mcand_d, target_q, target_d;
  logic [acpc_pkg::EN_W-1:0]            mplier_q, mplier_d, mag_q, mag_d;
  logic [acpc_pkg::ENERGY_W-1:0]        energy_q, energy_d;
  logic [acpc_pkg::K_W-1:0]             k_q, k_d, bit_q, bit_d, trial;
  logic [acpc_pkg::T2_W-1:0]            trial_sq;
  logic                                 neg_q, neg_d;
  logic signed [acpc_pkg::SCORE_W-1:0]  score_q, score_d;
  logic signed [acpc_pkg::XY_W-1:0]     xy_abs;

  assign xy_abs   = sums_i.xy[acpc_pkg::XY_W-1] ? -sums_i.xy : sums_i.xy;
  assign trial    = k_q | bit_q;
  assign trial_sq = trial * trial;

  always_comb begin
    state_d  = state_q;
    acc_d    = acc_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    target_d = target_q;
    mag_d    = mag_q;
    energy_d = energy_q;
    k_d      = k_q;
    bit_d    = bit_q;
    neg_d    = neg_q;
    score_d  = score_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (sums_i.xx == '0 || sums_i.yy == '0) begin
            score_d = '0;
            state_d = S_DONE;
          end else begin
            neg_d    = sums_i.xy[acpc_pkg::XY_W-1];
            mag_d    = acpc_pkg::EN_W'($unsigned(xy_abs));
            acc_d    = '0;
            mcand_d  = acpc_pkg::ACC_W'(sums_i.xx);
            mplier_d = sums_i.yy;
            state_d  = S_EMUL;
          end
        end
      end
      S_EMUL, S_TMUL, S_KMUL: begin
        if (mplier_q == '0) begin
          acc_d = '0;
          case (state_q)
            S_EMUL: begin
              energy_d = acc_q[acpc_pkg::ENERGY_W-1:0];
              mcand_d  = acpc_pkg::ACC_W'(mag_q);
              mplier_d = mag_q;
              state_d  = S_TMUL;
            end
            S_TMUL: begin
              target_d = {acc_q[acpc_pkg::ACC_W-acpc_pkg::T2_W-1:0],
                          {acpc_pkg::T2_W{1'b0}}};
              k_d      = '0;
              bit_d    = {1'b1, {(acpc_pkg::K_W-1){1'b0}}};
              state_d  = S_KSQ;
            end
            default: begin
              if (acc_q <= target_q) begin
                k_d = trial;
              end
              bit_d = bit_q >> 1;
              if (bit_q[0]) begin
                score_d = neg_q ? -$signed({1'b0, k_d}) : $signed({1'b0, k_d});
                state_d = S_DONE;
              end else begin
                state_d = S_KSQ;
              end
            end
          endcase
        end else begin
          if (mplier_q[0]) begin
            acc_d = acc_q + mcand_q;
          end
          mcand_d  = mcand_q << 1;
          mplier_d = mplier_q >> 1;
        end
      end
      S_KSQ: begin
        acc_d    = '0;
        mcand_d  = acpc_pkg::ACC_W'(energy_q);
        mplier_d = acpc_pkg::EN_W'(trial_sq);
        state_d  = S_KMUL;
      end
      S_DONE:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
    target_q <= target_d;
    mag_q    <= mag_d;
    energy_q <= energy_d;
    k_q      <= k_d;
    bit_q    <= bit_d;
    neg_q    <= neg_d;
    score_q  <= score_d;
  end

  assign done_o  = (state_q == S_DONE);
  assign score_o = score_q;
endmodule

/* rtl/acpc_div.sv */
// ----------------------------------------------------------------------------
// acpc_div
// restoring divider, one quotient bit per cycle, saturated frequency result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module acpc_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [acpc_pkg::DVD_W-1:0]    dividend_i,
  input  logic [acpc_pkg::LAG_W-1:0]    divisor_i,
  output logic                          done_o,
  output logic [acpc_pkg::FREQ_W-1:0]   quot_o
);
  localparam int CNT_BITS = $clog2(acpc_pkg::DVD_W + 1);

  logic [CNT_BITS-1:0]             cnt_q;
  logic                            done_q;
  logic [acpc_pkg::DVD_W-1:0]      dvd_q, q_q, q_next;
  logic [acpc_pkg::LAG_W-1:0]      div_q, rem_q;
  logic [acpc_pkg::LAG_W:0]        rem2, rem_sub;
  logic                            ge;
  logic [acpc_pkg::FREQ_W-1:0]     quot_q;

  assign rem2    = {rem_q, dvd_q[acpc_pkg::DVD_W-1]};
  assign ge      = rem2 >= {1'b0, div_q};
  assign rem_sub = rem2 - {1'b0, div_q};
  assign q_next  = {q_q[acpc_pkg::DVD_W-2:0], ge};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= CNT_BITS'(acpc_pkg::DVD_W);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - CNT_BITS'(1);
        if (cnt_q == CNT_BITS'(1)) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      div_q <= divisor_i;
      rem_q <= '0;
      q_q   <= '0;
    end else if (cnt_q != '0) begin
      dvd_q <= dvd_q << 1;
      rem_q <= ge ? rem_sub[acpc_pkg::LAG_W-1:0] : rem2[acpc_pkg::LAG_W-1:0];
      q_q   <= q_next;
      if (cnt_q == CNT_BITS'(1)) begin
        quot_q <= (|q_next[acpc_pkg::DVD_W-1:acpc_pkg::FREQ_W]) ? '1
                                                              : q_next[acpc_pkg::FREQ_W-1:0];
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
endmodule

/* rtl/autocorrelation_pitch_candidates_core.sv */
// ----------------------------------------------------------------------------
// autocorrelation_pitch_candidates_core
// pitch candidates of an audio frame from normalized autocorrelation peaks
// ----------------------------------------------------------------------------
// Samples are taken one beat per cycle until the beat that carries frame_end;
// up to 1024 samples are stored, the rest are dropped. The frame is then
// analyzed with the input closed: each lag from 30 to 400 goes through the
// correlation unit (one shared 16x16 multiplier) and then the shift-add
// scoring unit. A scan of the 371 stored scores ranks the peaks, and each
// candidate then passes through the serial divider before its result beat.
// Frames of 400 samples or fewer, or a candidate limit of zero, skip the
// analysis and give one not-found beat. Input opens again once the last result
// is in the output register.
`timescale 1ns / 1ps
`include "autocorrelation_pitch_candidates_core_macros.svh"
module autocorrelation_pitch_candidates_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [acpc_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                                 frame_end_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [acpc_pkg::FREQ_W-1:0]          frequency_o,
  output logic signed [acpc_pkg::SCORE_W-1:0]  score_o,
  output logic [acpc_pkg::LAG_W-1:0]           lag_o,
  output logic                                 found_o,
  output logic                                 run_end_o,
  input  logic                                 cfg_we_i,
  input  logic [acpc_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [acpc_pkg::CFG_W-1:0]           cfg_data_i
);
  localparam logic [3:0] T_LOAD   = 4'd0;
  localparam logic [3:0] T_SETUP  = 4'd1;
  localparam logic [3:0] T_CSTART = 4'd2;
  localparam logic [3:0] T_CWAIT  = 4'd3;
  localparam logic [3:0] T_SWAIT  = 4'd4;
  localparam logic [3:0] T_SRD    = 4'd5;
  localparam logic [3:0] T_SUSE   = 4'd6;
  localparam logic [3:0] T_BEST   = 4'd7;
  localparam logic [3:0] T_DSTART = 4'd8;
  localparam logic [3:0] T_DWAIT  = 4'd9;
  localparam logic [3:0] T_EMIT   = 4'd10;
  localparam logic [3:0] T_NONE   = 4'd11;

  logic [3:0]                           state_q, state_d;
  logic [acpc_pkg::LEN_W-1:0]           len_q, len_d, n_q, n_d, len_inc;
  logic [acpc_pkg::OFF_W-1:0]           off_q, off_d, best_off_q, best_off_d;
  logic [acpc_pkg::CNT_W-1:0]           cap_q, cap_d, cnt_q, cnt_d, ins_at, ins_cnt;
  logic [acpc_pkg::OIDX_W-1:0]          oidx_q, oidx_d;
  logic [acpc_pkg::SR_W-1:0]            sr_q;
  logic [acpc_pkg::LIM_W-1:0]           lim_q;
  acpc_pkg::cand_t                      list_q [acpc_pkg::MAX_CAND];
  acpc_pkg::cand_t                      list_ins [acpc_pkg::MAX_CAND];
  acpc_pkg::cand_t                      ins_cand, cur_cand;
  logic [acpc_pkg::MAX_CAND-1:0]        keep;
  logic                                 ins_en, do_ins, in_beat, wr_en, frame_full;
  logic signed [acpc_pkg::SCORE_W-1:0]  w1_q, w1_d, w2_q, w2_d, best_q, best_d, s_rd;
  logic [acpc_pkg::SCORE_W-1:0]         s_raw;
  logic                                 corr_start, corr_done, sc_start, sc_done;
  logic                                 div_start, div_done, out_load, out_free;
  acpc_pkg::corr_sums_t                 sums;
  logic signed [acpc_pkg::SCORE_W-1:0]  sc_score;
  logic [acpc_pkg::FREQ_W-1:0]          quot;
  logic [acpc_pkg::LAG_W-1:0]           corr_lag;
  logic                                 out_valid_q, found_q, found_d, run_end_q, run_end_d;
  logic [acpc_pkg::FREQ_W-1:0]          freq_q, freq_d;
  logic signed [acpc_pkg::SCORE_W-1:0]  oscore_q, oscore_d;
  logic [acpc_pkg::LAG_W-1:0]           olag_q, olag_d;

  assign in_ready_o = (state_q == T_LOAD);
  assign in_beat    = in_valid_i && in_ready_o;
  assign frame_full = len_q[acpc_pkg::FRAME_AW];
  assign wr_en      = in_beat && !frame_full;
  assign len_inc    = frame_full ? len_q : len_q + acpc_pkg::LEN_W'(1);
  assign corr_lag   = acpc_pkg::LAG_W'(off_q) + acpc_pkg::LAG_W'(acpc_pkg::MIN_LAG);
  assign s_rd       = $signed(s_raw);
  assign cur_cand   = list_q[oidx_q];
  assign out_free   = !out_valid_q || out_ready_i;

  acpc_corr u_corr (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .wr_en_i(wr_en), .wr_addr_i(len_q[acpc_pkg::FRAME_AW-1:0]), .wr_data_i(sample_i),
    .start_i(corr_start), .len_i(n_q), .lag_i(corr_lag),
    .done_o(corr_done), .sums_o(sums)
  );

  acpc_score u_score (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(sc_start), .sums_i(sums),
    .done_o(sc_done), .score_o(sc_score)
  );

  acpc_ram #(.WIDTH(acpc_pkg::SCORE_W), .DEPTH(acpc_pkg::LAG_COUNT)) u_score_ram (
    .clk_i(clk_i), .we_i(sc_done && state_q == T_SWAIT), .waddr_i(off_q),
    .wdata_i(sc_score), .raddr_i(off_q), .rdata_o(s_raw)
  );

  acpc_div u_div (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(div_start),
    .dividend_i({sr_q, 4'b0000}), .divisor_i(cur_cand.lag),
    .done_o(div_done), .quot_o(quot)
  );

  // ranked insertion, ties keep the earlier entry ahead
  always_comb begin
    for (int i = 0; i < acpc_pkg::MAX_CAND; i++) begin
      keep[i] = (acpc_pkg::CNT_W'(i) < cnt_q) && (list_q[i].score >= ins_cand.score);
    end
    ins_at = acpc_pkg::CNT_W'($countones(keep));
    do_ins = ins_en && !ins_cand.score[acpc_pkg::SCORE_W-1] && (ins_cand.score != '0)
             && (ins_at < cap_q);
    for (int i = 0; i < acpc_pkg::MAX_CAND; i++) begin
      if (keep[i]) begin
        list_ins[i] = list_q[i];
      end else if (i == 0) begin
        list_ins[i] = ins_cand;
      end else if (keep[i-1]) begin
        list_ins[i] = ins_cand;
      end else begin
        list_ins[i] = list_q[i-1];
      end
    end
    ins_cnt = (do_ins && cnt_q < cap_q) ? cnt_q + acpc_pkg::CNT_W'(1) : cnt_q;
  end

  always_comb begin
    state_d    = state_q;
    len_d      = len_q;
    n_d        = n_q;
    off_d      = off_q;
    best_off_d = best_off_q;
    cap_d      = cap_q;
    cnt_d      = cnt_q;
    oidx_d     = oidx_q;
    w1_d       = w1_q;
    w2_d       = w2_q;
    best_d     = best_q;
    ins_en     = 1'b0;
    ins_cand   = '{lag: acpc_pkg::LAG_W'(off_q) + acpc_pkg::LAG_W'(acpc_pkg::MIN_LAG - 1),
                   score: w2_q};
    corr_start = 1'b0;
    sc_start   = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    freq_d     = '0;
    oscore_d   = '0;
    olag_d     = '0;
    found_d    = 1'b0;
    run_end_d  = 1'b1;
    unique case (state_q)
      T_LOAD: begin
        if (in_beat) begin
          len_d = len_inc;
          if (frame_end_i) begin
            n_d     = len_inc;
            len_d   = '0;
            state_d = T_SETUP;
          end
        end
      end
      T_SETUP: begin
        cnt_d = '0;
        cap_d = (lim_q > acpc_pkg::LIM_W'(acpc_pkg::MAX_CAND))
                ? acpc_pkg::CNT_W'(acpc_pkg::MAX_CAND) : acpc_pkg::CNT_W'(lim_q);
        off_d = '0;
        if (n_q <= acpc_pkg::LEN_W'(acpc_pkg::MAX_LAG) || lim_q == '0) begin
          state_d = T_NONE;
        end else begin
          state_d = T_CSTART;
        end
      end
      T_CSTART: begin
        corr_start = 1'b1;
        state_d    = T_CWAIT;
      end
      T_CWAIT: begin
        if (corr_done) begin
          sc_start = 1'b1;
          state_d  = T_SWAIT;
        end
      end
      T_SWAIT: begin
        if (sc_done) begin
          if (off_q == acpc_pkg::OFF_W'(acpc_pkg::LAG_COUNT - 1)) begin
            off_d   = '0;
            state_d = T_SRD;
          end else begin
            off_d   = off_q + acpc_pkg::OFF_W'(1);
            state_d = T_CSTART;
          end
        end
      end
      T_SRD: state_d = T_SUSE;
      T_SUSE: begin
        // peak test for the previous lag, window holds the two scores before
        ins_en = (off_q >= acpc_pkg::OFF_W'(2)) && (w2_q >= w1_q) && (w2_q > s_rd);
        cnt_d  = ins_cnt;
        if (off_q == '0 || s_rd > best_q) begin
          best_d     = s_rd;
          best_off_d = off_q;
        end
        w1_d = w2_q;
        w2_d = s_rd;
        if (off_q == acpc_pkg::OFF_W'(acpc_pkg::LAG_COUNT - 1)) begin
          state_d = T_BEST;
        end else begin
          off_d   = off_q + acpc_pkg::OFF_W'(1);
          state_d = T_SRD;
        end
      end
      T_BEST: begin
        ins_cand = '{lag: acpc_pkg::LAG_W'(best_off_q) + acpc_pkg::LAG_W'(acpc_pkg::MIN_LAG),
                     score: best_q};
        ins_en   = (cnt_q == '0);
        cnt_d    = ins_cnt;
        oidx_d   = '0;
        state_d  = (ins_cnt == '0) ? T_NONE : T_DSTART;
      end
      T_DSTART: begin
        div_start = 1'b1;
        state_d   = T_DWAIT;
      end
      T_DWAIT: begin
        if (div_done) begin
          state_d = T_EMIT;
        end
      end
      T_EMIT: begin
        freq_d    = quot;
        oscore_d  = cur_cand.score;
        olag_d    = cur_cand.lag;
        found_d   = 1'b1;
        run_end_d = (acpc_pkg::CNT_W'(oidx_q) + acpc_pkg::CNT_W'(1) == cnt_q);
        if (out_free) begin
          out_load = 1'b1;
          if (run_end_d) begin
            state_d = T_LOAD;
          end else begin
            oidx_d  = oidx_q + acpc_pkg::OIDX_W'(1);
            state_d = T_DSTART;
          end
        end
      end
      T_NONE: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = T_LOAD;
        end
      end
      default: state_d = T_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= T_LOAD;
      len_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      sr_q        <= acpc_pkg::SR_RESET;
      lim_q       <= acpc_pkg::LIM_RESET;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          acpc_pkg::REG_SAMPLE_RATE: sr_q  <= cfg_data_i[acpc_pkg::SR_W-1:0];
          acpc_pkg::REG_CAND_LIMIT:  lim_q <= cfg_data_i[acpc_pkg::LIM_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    n_q        <= n_d;
    off_q      <= off_d;
    best_off_q <= best_off_d;
    cap_q      <= cap_d;
    oidx_q     <= oidx_d;
    w1_q       <= w1_d;
    w2_q       <= w2_d;
    best_q     <= best_d;
    if (do_ins) begin
      list_q <= list_ins;
    end
    if (out_load) begin
      freq_q    <= freq_d;
      oscore_q  <= oscore_d;
      olag_q    <= olag_d;
      found_q   <= found_d;
      run_end_q <= run_end_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign frequency_o = freq_q;
  assign score_o     = oscore_q;
  assign lag_o       = olag_q;
  assign found_o     = found_q;
  assign run_end_o   = run_end_q;

  `ACPC_ASSERT(a_cnt_cap, cnt_q <= acpc_pkg::CNT_W'(acpc_pkg::MAX_CAND), "ranked count over max")
  `ACPC_ASSERT(a_none_ends, out_valid_o && !found_o |-> run_end_o, "not-found beat without run end")
  `ACPC_ASSERT(a_lag_range, out_valid_o && found_o |-> lag_o >= acpc_pkg::LAG_W'(acpc_pkg::MIN_LAG) && lag_o <= acpc_pkg::LAG_W'(acpc_pkg::MAX_LAG), "candidate lag out of range")
  `ACPC_ASSERT(a_len_max, len_q <= acpc_pkg::LEN_W'(acpc_pkg::MAX_FRAME), "frame length over max")
endmodule
